// ----- rtl/core/efr_pkg.sv -----
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Parser phase codes, result kinds, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package efr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_OPEN_FLAG   = 2'd0;
  localparam logic [1:0] REG_CLOSE_FLAG  = 2'd1;
  localparam logic [1:0] REG_ESCAPE_BYTE = 2'd2;

  // Configuration reset values
  localparam logic [7:0] OPEN_FLAG_RST   = 8'd126;
  localparam logic [7:0] CLOSE_FLAG_RST  = 8'd127;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_CSUM_ERR = 2'd2;
  localparam logic [1:0] KIND_NO_END   = 2'd3;

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_LEN_HI  = 8'b0000_0010,
    PH_LEN_LO  = 8'b0000_0100,
    PH_TYPE    = 8'b0000_1000,
    PH_SUBTYPE = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CHECK   = 8'b0100_0000,
    PH_END     = 8'b1000_0000
  } phase_t;

  // One result as it travels from the parser to the output
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_subtype;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ----- rtl/core/escaped_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver: escaped-flag frame receiver with XOR checksum
// Parser front end feeding a small result queue that drives the output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one raw serial byte
//   per transaction. Output channel (out_valid / out_stall / kind and frame
//   fields) gives one transaction per payload byte (kind 0) and one final
//   status per frame (good, checksum error, end flag missing).
//   Throughput: one byte per cycle while in_stall is low; the parser step is
//   a single register update per byte. A result enters the queue as its byte
//   is taken and is shown once the results queued before it have left.
//   in_stall rises only when the QUEUE_DEPTH-entry result queue is full, so
//   a stalled receiver backs up into the input after QUEUE_DEPTH results.
//   The cfg_write port writes the open flag, close flag and escape byte
//   (index 0..2); index 3 is ignored. Write only while no frame results are
//   outstanding.
//   Reset (rst, synchronous) empties the queue, returns the parser to idle
//   and loads the flag registers with 126, 127 and 125.
// ----------------------------------------------------------------------------
module escaped_frame_receiver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_subtype,
  output logic [15:0] frame_length
);

  logic             accept;
  logic             push;
  logic             full;
  efr_pkg::result_t push_data;
  efr_pkg::result_t head;

  // Input transaction taken whenever the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  efr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_data (push_data)
  );

  efr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Output fields from the queue head
  assign kind          = head.kind;
  assign payload_byte  = head.payload_byte;
  assign frame_type    = head.frame_type;
  assign frame_subtype = head.frame_subtype;
  assign frame_length  = head.frame_length;

endmodule

// ----- rtl/core/efr_front.sv -----
// ----------------------------------------------------------------------------
// efr_front: frame parser
// Holds the flag registers, strips escapes, tracks the frame phase and the
// running XOR, and pushes one result per payload byte or frame end.
// ----------------------------------------------------------------------------
module efr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output efr_pkg::result_t  push_data
);

  efr_pkg::phase_t phase, phase_next;
  logic        esc_pending, esc_pending_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] hdr_len, hdr_len_next;
  logic [15:0] pay_cnt, pay_cnt_next;
  logic [15:0] pay_cnt_inc;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_subtype, held_subtype_next;
  logic [7:0]  open_flag, close_flag, escape_byte;

  assign pay_cnt_inc = pay_cnt + 16'd1;

  // Flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag   <= efr_pkg::OPEN_FLAG_RST;
      close_flag  <= efr_pkg::CLOSE_FLAG_RST;
      escape_byte <= efr_pkg::ESCAPE_BYTE_RST;
    end else if (cfg_write) begin
      if (cfg_index == efr_pkg::REG_OPEN_FLAG)   open_flag   <= cfg_data;
      if (cfg_index == efr_pkg::REG_CLOSE_FLAG)  close_flag  <= cfg_data;
      if (cfg_index == efr_pkg::REG_ESCAPE_BYTE) escape_byte <= cfg_data;
    end
  end

  // Per-byte parse step
  always_comb begin
    phase_next        = phase;
    esc_pending_next  = esc_pending;
    running_xor_next  = running_xor;
    hdr_len_next      = hdr_len;
    pay_cnt_next      = pay_cnt;
    held_type_next    = held_type;
    held_subtype_next = held_subtype;
    push              = 1'b0;
    push_data         = '0;
    if (accept) begin
      if (phase == efr_pkg::PH_IDLE) begin
        // only the start flag opens a frame
        if (rx_byte == open_flag) begin
          phase_next        = efr_pkg::PH_LEN_HI;
          esc_pending_next  = 1'b0;
          running_xor_next  = '0;
          hdr_len_next      = '0;
          pay_cnt_next      = '0;
          held_type_next    = '0;
          held_subtype_next = '0;
        end
      end else if (phase == efr_pkg::PH_END) begin
        // raw end byte; checksum error takes precedence
        push                    = 1'b1;
        push_data.frame_type    = held_type;
        push_data.frame_subtype = held_subtype;
        push_data.frame_length  = hdr_len;
        if (running_xor != 8'd0)        push_data.kind = efr_pkg::KIND_CSUM_ERR;
        else if (rx_byte == close_flag) push_data.kind = efr_pkg::KIND_GOOD;
        else                            push_data.kind = efr_pkg::KIND_NO_END;
        phase_next       = efr_pkg::PH_IDLE;
        esc_pending_next = 1'b0;
      end else if (!esc_pending && rx_byte == escape_byte) begin
        esc_pending_next = 1'b1;
      end else begin
        esc_pending_next = 1'b0;
        running_xor_next = running_xor ^ rx_byte;
        unique case (phase)
          efr_pkg::PH_LEN_HI: begin
            hdr_len_next = {rx_byte, 8'd0};
            phase_next   = efr_pkg::PH_LEN_LO;
          end
          efr_pkg::PH_LEN_LO: begin
            hdr_len_next = {hdr_len[15:8], rx_byte};
            phase_next   = efr_pkg::PH_TYPE;
          end
          efr_pkg::PH_TYPE: begin
            held_type_next = rx_byte;
            phase_next     = efr_pkg::PH_SUBTYPE;
          end
          efr_pkg::PH_SUBTYPE: begin
            held_subtype_next = rx_byte;
            phase_next = (hdr_len == 16'd0) ? efr_pkg::PH_CHECK : efr_pkg::PH_PAYLOAD;
          end
          efr_pkg::PH_PAYLOAD: begin
            pay_cnt_next           = pay_cnt_inc;
            if (pay_cnt_inc >= hdr_len) phase_next = efr_pkg::PH_CHECK;
            push                   = 1'b1;
            push_data.kind         = efr_pkg::KIND_PAYLOAD;
            push_data.payload_byte = rx_byte;
          end
          default: begin
            // checksum byte
            phase_next = efr_pkg::PH_END;
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= efr_pkg::PH_IDLE;
      esc_pending  <= 1'b0;
      running_xor  <= '0;
      hdr_len      <= '0;
      pay_cnt      <= '0;
      held_type    <= '0;
      held_subtype <= '0;
    end else begin
      phase        <= phase_next;
      esc_pending  <= esc_pending_next;
      running_xor  <= running_xor_next;
      hdr_len      <= hdr_len_next;
      pay_cnt      <= pay_cnt_next;
      held_type    <= held_type_next;
      held_subtype <= held_subtype_next;
    end
  end

  // Results come only from payload bytes or the end position
  a_push_phase: assert property (@(posedge clk) disable iff (rst)
    push |-> (phase == efr_pkg::PH_PAYLOAD || phase == efr_pkg::PH_END))
    else $error("efr_front: result pushed outside payload or end phase");

  // Escape is never pending while idle
  a_idle_no_esc: assert property (@(posedge clk) disable iff (rst)
    (phase == efr_pkg::PH_IDLE) |-> !esc_pending)
    else $error("efr_front: escape pending while idle");

endmodule

// ----- rtl/core/efr_queue.sv -----
// ----------------------------------------------------------------------------
// efr_queue: result queue and output side
// Small circular queue between the parser and the result channel; the head
// entry drives the output ports directly and holds while stalled.
// ----------------------------------------------------------------------------
module efr_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  efr_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output efr_pkg::result_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  efr_pkg::result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full      = (count == FULL_CNT);
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("efr_queue: push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("efr_queue: count beyond depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("efr_queue: transaction taken but count did not drop");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for escaped_frame_receiver
// Feeds raw serial bytes (idle junk, escaped frames with good and bad
// checksums, bad end flags, wrong lengths and cut-off frames) under several
// flag settings. A byte-level model of the parser predicts every payload byte
// and final status; results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [7:0] byte_q_t[$];
  typedef logic [1:0] index_q_t[$];

  localparam logic [1:0] REG_UNUSED = 2'd3;   // index with no register behind it

  localparam logic [1:0] STALL_NONE    = 2'd0;
  localparam logic [1:0] STALL_LIGHT   = 2'd1;
  localparam logic [1:0] STALL_HEAVY   = 2'd2;
  localparam logic [1:0] STALL_PATTERN = 2'd3;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTS  = 40;
  localparam int PHASE_ITEMS = 290;

  // Byte-level model of the parser plus the in-order result check
  class frame_checker;
    logic [7:0]          open_flag;
    logic [7:0]          close_flag;
    logic [7:0]          escape_byte;
    efr_pkg::phase_t     phase;
    bit                  esc_pending;
    logic [7:0]          running_sum;
    logic [15:0]         header_len;
    logic [15:0]         payload_seen;
    logic [7:0]          held_type;
    logic [7:0]          held_subtype;
    efr_pkg::result_t    pending_results[$];
    int                  errors;

    function new();
      open_flag    = efr_pkg::OPEN_FLAG_RST;
      close_flag   = efr_pkg::CLOSE_FLAG_RST;
      escape_byte  = efr_pkg::ESCAPE_BYTE_RST;
      phase        = efr_pkg::PH_IDLE;
      esc_pending  = 1'b0;
      running_sum  = 8'h00;
      header_len   = 16'h0000;
      payload_seen = 16'h0000;
      held_type    = 8'h00;
      held_subtype = 8'h00;
      errors       = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [7:0] value);
      case (idx)
        efr_pkg::REG_OPEN_FLAG:   open_flag = value;
        efr_pkg::REG_CLOSE_FLAG:  close_flag = value;
        efr_pkg::REG_ESCAPE_BYTE: escape_byte = value;
        default: ;
      endcase
    endfunction

    // One accepted raw byte; queues the result it causes, if any
    function void parse_byte(input logic [7:0] b);
      efr_pkg::result_t r;
      r = '0;
      if (phase == efr_pkg::PH_IDLE) begin
        if (b == open_flag) begin
          phase        = efr_pkg::PH_LEN_HI;
          esc_pending  = 1'b0;
          running_sum  = 8'h00;
          header_len   = 16'h0000;
          payload_seen = 16'h0000;
          held_type    = 8'h00;
          held_subtype = 8'h00;
        end
        return;
      end
      // End position: raw byte, always consumed
      if (phase == efr_pkg::PH_END) begin
        if (running_sum != 8'h00) r.kind = efr_pkg::KIND_CSUM_ERR;
        else if (b == close_flag) r.kind = efr_pkg::KIND_GOOD;
        else r.kind = efr_pkg::KIND_NO_END;
        r.frame_type    = held_type;
        r.frame_subtype = held_subtype;
        r.frame_length  = header_len;
        pending_results.push_back(r);
        phase       = efr_pkg::PH_IDLE;
        esc_pending = 1'b0;
        return;
      end
      if (!esc_pending && b == escape_byte) begin
        esc_pending = 1'b1;
        return;
      end
      esc_pending = 1'b0;
      running_sum = running_sum ^ b;
      case (phase)
        efr_pkg::PH_LEN_HI: begin
          header_len = {b, 8'h00};
          phase = efr_pkg::PH_LEN_LO;
        end
        efr_pkg::PH_LEN_LO: begin
          header_len[7:0] = b;
          phase = efr_pkg::PH_TYPE;
        end
        efr_pkg::PH_TYPE: begin
          held_type = b;
          phase = efr_pkg::PH_SUBTYPE;
        end
        efr_pkg::PH_SUBTYPE: begin
          held_subtype = b;
          if (header_len == 16'h0000) phase = efr_pkg::PH_CHECK;
          else phase = efr_pkg::PH_PAYLOAD;
        end
        efr_pkg::PH_PAYLOAD: begin
          payload_seen = payload_seen + 16'd1;
          if (payload_seen >= header_len) phase = efr_pkg::PH_CHECK;
          r.kind = efr_pkg::KIND_PAYLOAD;
          r.payload_byte = b;
          pending_results.push_back(r);
        end
        default: phase = efr_pkg::PH_END;
      endcase
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ERROR %s", $time, msg);
    endtask

    task check_result(input efr_pkg::result_t got);
      efr_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h",
                         got.kind, got.payload_byte));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d expected %0d", got.kind, want.kind));
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte got %02h expected %02h",
                         got.payload_byte, want.payload_byte));
      if (got.frame_type !== want.frame_type)
        report($sformatf("frame_type got %02h expected %02h",
                         got.frame_type, want.frame_type));
      if (got.frame_subtype !== want.frame_subtype)
        report($sformatf("frame_subtype got %02h expected %02h",
                         got.frame_subtype, want.frame_subtype));
      if (got.frame_length !== want.frame_length)
        report($sformatf("frame_length got %04h expected %04h",
                         got.frame_length, want.frame_length));
    endtask

    task close_out();
      if (pending_results.size() != 0)
        report($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_type;
  logic [7:0]  frame_subtype;
  logic [15:0] frame_length;

  frame_checker sb;       // follows accepted bytes, checks results
  frame_checker shadow;   // follows generated bytes, steers the generator

  int          burst_left = 0;
  int          frame_items = 0;
  int          quiet_cycles = 0;
  logic [1:0]  stall_mode = STALL_NONE;
  logic [7:0]  mode_timer = 8'h00;
  logic [15:0] stall_pat = 16'hF0C3;

  escaped_frame_receiver u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .frame_type    (frame_type),
    .frame_subtype (frame_subtype),
    .frame_length  (frame_length)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stall, switching pattern each time the 8-bit mode timer wraps
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      mode_timer <= mode_timer + 8'd1;
      stall_pat  <= {stall_pat[14:0], stall_pat[15]};
      if (mode_timer == 8'h00) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= stall_pat[15];
      endcase
    end
  end

  // Monitor: check the result first, then predict from the accepted byte
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result({kind, payload_byte, frame_type, frame_subtype, frame_length});
      if (in_valid && !in_stall) sb.parse_byte(rx_byte);
    end
  end

  // Watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("escaped_frame_receiver regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_except(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == x) b = b + 8'd1;
    return b;
  endfunction

  // One transaction on the input; sender idles between bursts
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        gap = 0;
        burst_left = $urandom_range(100, 300);
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 24);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic put(input logic [7:0] b);
    if (shadow.phase != efr_pkg::PH_IDLE || b == shadow.open_flag) frame_items++;
    shadow.parse_byte(b);
    shadow.pending_results.delete();
    send_byte(b);
  endtask

  // Escaped field; extra escapes only where they cannot land outside a frame
  task automatic put_field(input logic [7:0] b);
    if (b == shadow.escape_byte ||
        (shadow.phase != efr_pkg::PH_IDLE && shadow.phase != efr_pkg::PH_END &&
         $urandom_range(0, 7) == 0))
      put(shadow.escape_byte);
    put(b);
  endtask

  // Finish whatever frame is open, keeping any length it reads small
  task automatic flush_parser();
    logic [7:0] b;
    while (shadow.phase != efr_pkg::PH_IDLE) begin
      if (shadow.phase == efr_pkg::PH_LEN_HI || shadow.phase == efr_pkg::PH_LEN_LO)
        b = (shadow.escape_byte == 8'h00) ? 8'h01 : 8'h00;
      else
        b = rand_except(shadow.escape_byte);
      put(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fsub,
                            input logic [15:0] len_field, input byte_q_t payload,
                            input logic [7:0] sum_flip, input logic [7:0] end_raw,
                            input int cut_at);
    logic [7:0] body[$];
    logic [7:0] sum;
    body = {len_field[15:8], len_field[7:0], ftype, fsub};
    foreach (payload[i]) body.push_back(payload[i]);
    sum = 8'h00;
    foreach (body[i]) sum = sum ^ body[i];
    // a misaligned checksum may spill past the frame: keep it off the start flag
    if (len_field != payload.size() && (sum ^ sum_flip) == shadow.open_flag)
      sum_flip = sum_flip ^ 8'h01;
    body.push_back(sum ^ sum_flip);
    put(shadow.open_flag);
    for (int i = 0; i < body.size(); i++) begin
      if (i == cut_at) break;
      put_field(body[i]);
    end
    if (cut_at < 0) put(end_raw);
    flush_parser();
  endtask

  task automatic write_regs(input index_q_t idx, input byte_q_t value);
    foreach (idx[i]) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= value[i];
      @(posedge clk);
      sb.write_reg(idx[i], value[i]);
      shadow.write_reg(idx[i], value[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Let every expected result come out before going on
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(input int budget);
    int          goal;
    int          pick;
    int          len;
    int          cut;
    bit          broken;
    logic [15:0] len_field;
    logic [7:0]  flip;
    logic [7:0]  end_raw;
    byte_q_t     pl;
    goal = frame_items + budget;
    while (frame_items < goal) begin
      repeat ($urandom_range(0, 2)) put(rand_except(shadow.open_flag));
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 10);
      pick = $urandom_range(0, 99);
      flip = 8'h00;
      end_raw = shadow.close_flag;
      cut = -1;
      broken = 1'b0;
      len_field = 16'(len);
      if (pick >= 70 && pick < 78) begin
        flip = 8'($urandom_range(1, 255));
      end else if (pick >= 78 && pick < 86) begin
        end_raw = rand_except(shadow.close_flag);
      end else if (pick >= 86 && pick < 90) begin
        flip = 8'($urandom_range(1, 255));
        end_raw = rand_except(shadow.close_flag);
      end else if (pick >= 90 && pick < 95) begin
        // header length disagrees with the bytes sent
        broken = 1'b1;
        if (len > 2 && $urandom_range(0, 1) == 1) len_field = 16'(len - $urandom_range(1, 2));
        else len_field = 16'(len + $urandom_range(1, 3));
        if (shadow.close_flag == shadow.open_flag) end_raw = rand_except(shadow.open_flag);
      end else if (pick >= 95) begin
        cut = $urandom_range(0, len + 5);
      end
      pl.delete();
      repeat (len) pl.push_back(broken ? rand_except(shadow.open_flag) : 8'($urandom));
      send_frame(8'($urandom), 8'($urandom), len_field, pl, flip, end_raw, cut);
    end
  endtask

  initial begin
    byte_q_t none;
    sb = new();
    shadow = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset flags: junk while idle, escaped header and payload
    put(8'h00);
    put(8'hFF);
    put(efr_pkg::ESCAPE_BYTE_RST);
    send_frame(efr_pkg::ESCAPE_BYTE_RST, 8'hFF, 16'd3,
               {efr_pkg::OPEN_FLAG_RST, efr_pkg::ESCAPE_BYTE_RST, efr_pkg::CLOSE_FLAG_RST},
               8'h00, efr_pkg::CLOSE_FLAG_RST, -1);
    // bad checksum and start flag at the end position: checksum error wins
    send_frame(8'h00, 8'h01, 16'd1, {8'h00}, 8'h80, efr_pkg::OPEN_FLAG_RST, -1);
    put(8'h03);
    // zero length, checksum equal to the escape byte, escape byte at the end position
    send_frame(efr_pkg::ESCAPE_BYTE_RST, 8'h00, 16'd0, none, 8'h00,
               efr_pkg::ESCAPE_BYTE_RST, -1);
    run_random(PHASE_ITEMS);
    drain();

    // Low start flag, high end flag; stray write to the unused index
    write_regs({efr_pkg::REG_OPEN_FLAG, efr_pkg::REG_CLOSE_FLAG, efr_pkg::REG_ESCAPE_BYTE,
                REG_UNUSED},
               {8'h00, 8'hFF, 8'h80, 8'hA5});
    run_random(PHASE_ITEMS);
    drain();

    // Opposite extremes
    write_regs({efr_pkg::REG_OPEN_FLAG, efr_pkg::REG_CLOSE_FLAG, efr_pkg::REG_ESCAPE_BYTE},
               {8'hFF, 8'h00, 8'hFF});
    run_random(PHASE_ITEMS);
    drain();

    // Start, end and escape all the same byte
    write_regs({efr_pkg::REG_OPEN_FLAG, efr_pkg::REG_CLOSE_FLAG, efr_pkg::REG_ESCAPE_BYTE},
               {8'h55, 8'h55, 8'h55});
    run_random(PHASE_ITEMS);
    drain();

    // Escape of zero, random flags
    write_regs({efr_pkg::REG_OPEN_FLAG, efr_pkg::REG_CLOSE_FLAG, efr_pkg::REG_ESCAPE_BYTE},
               {8'($urandom), 8'($urandom), 8'h00});
    run_random(PHASE_ITEMS);
    drain();

    // All random
    write_regs({efr_pkg::REG_OPEN_FLAG, efr_pkg::REG_CLOSE_FLAG, efr_pkg::REG_ESCAPE_BYTE},
               {8'($urandom), 8'($urandom), 8'($urandom)});
    run_random(PHASE_ITEMS);
    drain();

    sb.close_out();
    if (sb.errors == 0) $display("escaped_frame_receiver regression: pass");
    else $display("escaped_frame_receiver regression: fail");
    $finish;
  end

endmodule
